@@ hw/rtl/ubd_pkg.sv @@
// shared types, byte constants and a helper for the unicode stream decoder
`default_nettype none

package ubd_pkg;

   typedef enum logic [2:0] {
      ENC_UTF8  = 3'd0,
      ENC_U16BE = 3'd1,
      ENC_U16LE = 3'd2,
      ENC_U32BE = 3'd3,
      ENC_U32LE = 3'd4,
      ENC_ASCII = 3'd5
   } enc_type;

   // byte order mark bytes
   localparam logic [7:0] BYTE_00 = 8'h00;
   localparam logic [7:0] BYTE_FE = 8'hFE;
   localparam logic [7:0] BYTE_FF = 8'hFF;
   localparam logic [7:0] BYTE_EF = 8'hEF;
   localparam logic [7:0] BYTE_BB = 8'hBB;
   localparam logic [7:0] BYTE_BF = 8'hBF;

   // utf-8 lead byte boundaries
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_BAD   = 8'hF8;

   localparam logic [20:0] SURR_LOW  = 21'h00D800;
   localparam logic [20:0] SURR_HIGH = 21'h00DFFF;
   localparam logic [20:0] CP_MAX    = 21'h10FFFF;
   localparam logic [31:0] SUPP_BASE = 32'h0001_0000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_word_type;

   typedef struct packed {
      logic [31:0] code_point;
      logic [2:0]  encoding_now;
      logic        mark_found;
      logic        last_of_run;
   } rsp_word_type;

   typedef struct packed {
      enc_type     enc;
      logic [31:0] accum;
      logic [1:0]  unit_cnt;
      logic [15:0] pend;
      logic [1:0]  utf8_rem;
   } dec_state_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] code_point;
      enc_type     enc;
   } dec_result_type;

   typedef struct packed {
      logic push;
      logic run_end;
   } queue_ctrl_type;

   function automatic enc_type start_encoding(input logic [2:0] value);
      enc_type enc;
      if (value > ENC_ASCII) begin
         enc = ENC_UTF8;
      end else begin
         enc = enc_type'(value);
      end
      return enc;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ubd_decode.sv @@
// one byte step of the utf-32, utf-16, utf-8 and ascii decoders
`default_nettype none

module ubd_decode (
   input  ubd_pkg::dec_state_type  state_cur,
   input  logic [7:0]              data_byte,
   output ubd_pkg::dec_state_type  state_nxt,
   output ubd_pkg::dec_result_type result
);

   logic [31:0] word32;
   logic [15:0] unit16;
   logic        surr;
   logic [20:0] seq_val;
   logic [20:0] seq_min;
   logic        seq_bad;
   logic        is_ascii;

   always_comb begin
      state_nxt = state_cur;
      result    = '0;

      word32 = (state_cur.enc == ubd_pkg::ENC_U32BE) ?
               {state_cur.accum[23:0], data_byte} :
               {data_byte, state_cur.accum[31:8]};
      unit16 = (state_cur.enc == ubd_pkg::ENC_U16BE) ?
               {state_cur.accum[7:0], data_byte} :
               {data_byte, state_cur.accum[7:0]};
      surr   = (unit16[15:11] == 5'b11011);

      seq_val = {state_cur.accum[14:0], data_byte[5:0]};
      case (state_cur.unit_cnt)
         2'd1:    seq_min = 21'h000080;
         2'd2:    seq_min = 21'h000800;
         default: seq_min = 21'h010000;
      endcase
      seq_bad = (seq_val < seq_min) ||
                (seq_val >= ubd_pkg::SURR_LOW && seq_val <= ubd_pkg::SURR_HIGH) ||
                (seq_val > ubd_pkg::CP_MAX);
      is_ascii = (data_byte != 8'd0) && (data_byte < ubd_pkg::UTF8_CONT);

      unique case (state_cur.enc) inside
         ubd_pkg::ENC_U32BE, ubd_pkg::ENC_U32LE: begin
            if (state_cur.unit_cnt == 2'd3) begin
               result.valid        = 1'b1;
               result.code_point   = word32;
               state_nxt.accum     = '0;
               state_nxt.unit_cnt  = 2'd0;
            end else begin
               state_nxt.accum     = word32;
               state_nxt.unit_cnt  = state_cur.unit_cnt + 2'd1;
            end
         end
         ubd_pkg::ENC_U16BE, ubd_pkg::ENC_U16LE: begin
            if (state_cur.unit_cnt == 2'd0) begin
               state_nxt.accum    = {24'd0, data_byte};
               state_nxt.unit_cnt = 2'd1;
            end else begin
               state_nxt.accum    = '0;
               state_nxt.unit_cnt = 2'd0;
               if (state_cur.pend != 16'd0) begin
                  // second half of a pair; a non-surrogate loses both units
                  if (surr) begin
                     result.valid      = 1'b1;
                     result.code_point = ubd_pkg::SUPP_BASE +
                                         {12'd0, state_cur.pend[9:0], unit16[9:0]};
                  end
                  state_nxt.pend = '0;
               end else if (surr) begin
                  state_nxt.pend = unit16;
               end else begin
                  result.valid      = 1'b1;
                  result.code_point = {16'd0, unit16};
               end
            end
         end
         ubd_pkg::ENC_ASCII: begin
            if (is_ascii) begin
               result.valid      = 1'b1;
               result.code_point = {24'd0, data_byte};
            end
         end
         default: begin
            if (state_cur.utf8_rem == 2'd0) begin
               if (data_byte == 8'd0 ||
                   (data_byte >= ubd_pkg::UTF8_CONT && data_byte < ubd_pkg::UTF8_LEAD2) ||
                   data_byte >= ubd_pkg::UTF8_BAD) begin
                  state_nxt.enc      = ubd_pkg::ENC_ASCII;
                  state_nxt.accum    = '0;
                  state_nxt.unit_cnt = 2'd0;
                  state_nxt.utf8_rem = 2'd0;
               end else if (data_byte < ubd_pkg::UTF8_CONT) begin
                  result.valid      = 1'b1;
                  result.code_point = {24'd0, data_byte};
               end else if (data_byte < ubd_pkg::UTF8_LEAD3) begin
                  state_nxt.accum    = {27'd0, data_byte[4:0]};
                  state_nxt.utf8_rem = 2'd1;
                  state_nxt.unit_cnt = 2'd1;
               end else if (data_byte < ubd_pkg::UTF8_LEAD4) begin
                  state_nxt.accum    = {28'd0, data_byte[3:0]};
                  state_nxt.utf8_rem = 2'd2;
                  state_nxt.unit_cnt = 2'd2;
               end else begin
                  state_nxt.accum    = {29'd0, data_byte[2:0]};
                  state_nxt.utf8_rem = 2'd3;
                  state_nxt.unit_cnt = 2'd3;
               end
            end else if (data_byte[7:6] != 2'b10) begin
               // missing continuation: fall back, then treat this byte as ascii
               state_nxt.enc      = ubd_pkg::ENC_ASCII;
               state_nxt.accum    = '0;
               state_nxt.unit_cnt = 2'd0;
               state_nxt.utf8_rem = 2'd0;
               if (is_ascii) begin
                  result.valid      = 1'b1;
                  result.code_point = {24'd0, data_byte};
               end
            end else if (state_cur.utf8_rem == 2'd1) begin
               state_nxt.accum    = '0;
               state_nxt.unit_cnt = 2'd0;
               state_nxt.utf8_rem = 2'd0;
               if (seq_bad) begin
                  state_nxt.enc = ubd_pkg::ENC_ASCII;
               end else begin
                  result.valid      = 1'b1;
                  result.code_point = {11'd0, seq_val};
               end
            end else begin
               state_nxt.accum    = {11'd0, seq_val};
               state_nxt.utf8_rem = state_cur.utf8_rem - 2'd1;
            end
         end
      endcase

      result.enc = state_nxt.enc;
   end

endmodule

`default_nettype wire

@@ hw/rtl/ubd_result_queue.sv @@
// hold stage and output register that mark the last word of each run
`default_nettype none

module ubd_result_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ubd_pkg::queue_ctrl_type ctrl,
   input  ubd_pkg::rsp_word_type  push_word,
   output logic                   can_take,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ubd_pkg::rsp_word_type  rsp_word
);

   logic                  hold_valid_ff, hold_valid_in;
   logic                  hold_last_ff, hold_last_in;
   ubd_pkg::rsp_word_type hold_word_ff, hold_word_in;
   logic                  out_valid_ff, out_valid_in;
   ubd_pkg::rsp_word_type out_word_ff, out_word_in;
   logic                  out_free;
   logic                  hold_move;

   assign out_free  = !out_valid_ff || !rsp_stall;
   // a word leaves the hold stage once its run is known to be over or the next word shows up
   assign hold_move = hold_valid_ff && out_free && (hold_last_ff || ctrl.push);
   assign can_take  = !hold_valid_ff || out_free;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (hold_move) begin
         out_valid_in             = 1'b1;
         out_word_in              = hold_word_ff;
         out_word_in.last_of_run  = hold_last_ff;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end

      hold_valid_in = hold_valid_ff;
      hold_last_in  = hold_last_ff;
      hold_word_in  = hold_word_ff;
      if (ctrl.push) begin
         hold_valid_in = 1'b1;
         hold_last_in  = ctrl.run_end;
         hold_word_in  = push_word;
      end else if (hold_move) begin
         hold_valid_in = 1'b0;
         hold_last_in  = 1'b0;
      end else if (ctrl.run_end && hold_valid_ff) begin
         hold_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_last_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         hold_last_ff  <= hold_last_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_word_ff <= hold_word_in;
      out_word_ff  <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> can_take)
      else $error("word pushed while hold stage cannot take it");

   a_out_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(hold_valid_ff))
      else $error("output register loaded without a held word");

   a_open_run_waits: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !hold_last_ff && !ctrl.push |=> hold_valid_ff)
      else $error("word of an unfinished run left the hold stage");

endmodule

`default_nettype wire

@@ hw/rtl/unicode_stream_decoder_bom.sv @@
// byte order mark detection and unicode decoding, one byte per cycle unless stalled
// a word passes from the input register through the decoder, the hold stage and the output register to rsp
// throughput: one byte per cycle unless rsp stalls; when the mark decision leaves held bytes to decode,
//   req stalls while those held bytes (up to four) pass through the decoder in order
// reset: synchronous, clears all control state and sets the encoding register to utf-8
`default_nettype none

module unicode_stream_decoder_bom (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ubd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ubd_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_write_data
);

   // input register
   logic                  in_valid_ff, in_valid_in;
   ubd_pkg::req_word_type in_word_ff;
   logic                  req_take;
   logic                  in_take;

   // stream state
   logic [2:0]             init_enc_ff, init_enc_in;
   logic [3:0][7:0]        head_ff, head_in;
   logic [1:0]             head_cnt_ff, head_cnt_in;
   logic                   decided_ff, decided_in;
   logic                   mark_ff, mark_in;
   ubd_pkg::dec_state_type dec_ff, dec_in;

   // replay of held bytes after the mark decision
   logic       replay_ff, replay_in;
   logic [1:0] replay_idx_ff, replay_idx_in;
   logic [1:0] replay_last_ff, replay_last_in;
   logic       replay_eos_ff, replay_eos_in;

   logic                    can_take;
   logic                    src_take;
   logic [7:0]              src_byte;
   logic                    src_final;
   logic                    src_eos;
   logic                    use_dec;
   ubd_pkg::dec_state_type  dec_nxt;
   ubd_pkg::dec_result_type dec_res;
   ubd_pkg::queue_ctrl_type q_ctrl;
   ubd_pkg::rsp_word_type   push_word;

   logic [3:0][7:0]  head_view;
   logic             mark_hit;
   ubd_pkg::enc_type mark_enc;
   logic [2:0]       mark_skip;
   logic             replay_need;

   assign in_take   = in_valid_ff && !replay_ff && can_take;
   assign req_stall = in_valid_ff && !in_take;
   assign req_take  = req_valid && !req_stall;
   assign src_take  = can_take && (replay_ff || in_valid_ff);
   assign src_byte  = replay_ff ? head_ff[replay_idx_ff] : in_word_ff.data_byte;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end
   end

   // mark check over the held bytes plus the incoming one
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         head_view[i] = (2'(i) == head_cnt_ff) ? in_word_ff.data_byte : head_ff[i];
      end
      mark_hit  = 1'b1;
      mark_enc  = dec_ff.enc;
      mark_skip = 3'd0;
      if (head_cnt_ff == 2'd3 && head_view[0] == ubd_pkg::BYTE_00 &&
          head_view[1] == ubd_pkg::BYTE_00 && head_view[2] == ubd_pkg::BYTE_FE &&
          head_view[3] == ubd_pkg::BYTE_FF) begin
         mark_enc  = ubd_pkg::ENC_U32BE;
         mark_skip = 3'd4;
      end else if (head_cnt_ff == 2'd3 && head_view[0] == ubd_pkg::BYTE_FF &&
                   head_view[1] == ubd_pkg::BYTE_FE && head_view[2] == ubd_pkg::BYTE_00 &&
                   head_view[3] == ubd_pkg::BYTE_00) begin
         mark_enc  = ubd_pkg::ENC_U32LE;
         mark_skip = 3'd4;
      end else if (head_cnt_ff >= 2'd2 && head_view[0] == ubd_pkg::BYTE_EF &&
                   head_view[1] == ubd_pkg::BYTE_BB && head_view[2] == ubd_pkg::BYTE_BF) begin
         mark_enc  = ubd_pkg::ENC_UTF8;
         mark_skip = 3'd3;
      end else if (head_cnt_ff >= 2'd1 && head_view[0] == ubd_pkg::BYTE_FE &&
                   head_view[1] == ubd_pkg::BYTE_FF) begin
         mark_enc  = ubd_pkg::ENC_U16BE;
         mark_skip = 3'd2;
      end else if (head_cnt_ff >= 2'd1 && head_view[0] == ubd_pkg::BYTE_FF &&
                   head_view[1] == ubd_pkg::BYTE_FE) begin
         mark_enc  = ubd_pkg::ENC_U16LE;
         mark_skip = 3'd2;
      end else begin
         mark_hit = 1'b0;
      end
      replay_need = {1'b0, head_cnt_ff} >= mark_skip;
   end

   ubd_decode u_decode (
      .state_cur (dec_ff),
      .data_byte (src_byte),
      .state_nxt (dec_nxt),
      .result    (dec_res)
   );

   always_comb begin
      init_enc_in    = init_enc_ff;
      head_in        = head_ff;
      head_cnt_in    = head_cnt_ff;
      decided_in     = decided_ff;
      mark_in        = mark_ff;
      dec_in         = dec_ff;
      replay_in      = replay_ff;
      replay_idx_in  = replay_idx_ff;
      replay_last_in = replay_last_ff;
      replay_eos_in  = replay_eos_ff;
      src_final      = 1'b0;
      src_eos        = 1'b0;
      use_dec        = 1'b0;

      if (src_take) begin
         if (replay_ff) begin
            use_dec   = 1'b1;
            dec_in    = dec_nxt;
            src_final = (replay_idx_ff == replay_last_ff);
            src_eos   = replay_eos_ff;
            if (src_final) begin
               replay_in = 1'b0;
            end else begin
               replay_idx_in = replay_idx_ff + 2'd1;
            end
         end else if (decided_ff) begin
            use_dec   = 1'b1;
            dec_in    = dec_nxt;
            src_final = 1'b1;
            src_eos   = in_word_ff.end_of_stream;
         end else begin
            head_in[head_cnt_ff] = in_word_ff.data_byte;
            if (head_cnt_ff == 2'd3 || in_word_ff.end_of_stream) begin
               decided_in  = 1'b1;
               head_cnt_in = 2'd0;
               if (mark_hit) begin
                  dec_in.enc = mark_enc;
                  mark_in    = 1'b1;
               end
               if (replay_need) begin
                  replay_in      = 1'b1;
                  replay_idx_in  = mark_skip[1:0];
                  replay_last_in = head_cnt_ff;
                  replay_eos_in  = in_word_ff.end_of_stream;
               end else begin
                  src_final = 1'b1;
                  src_eos   = in_word_ff.end_of_stream;
               end
            end else begin
               head_cnt_in = head_cnt_ff + 2'd1;
               src_final   = 1'b1;
            end
         end

         // end of stream: back to the start-of-stream state
         if (src_final && src_eos) begin
            dec_in      = '0;
            dec_in.enc  = ubd_pkg::start_encoding(init_enc_ff);
            decided_in  = 1'b0;
            mark_in     = 1'b0;
            head_cnt_in = 2'd0;
            replay_in   = 1'b0;
         end
      end

      if (csr_write_enable) begin
         init_enc_in = csr_write_data;
         if (!decided_ff) begin
            dec_in.enc = ubd_pkg::start_encoding(csr_write_data);
         end
      end
   end

   always_comb begin
      q_ctrl.push             = src_take && use_dec && dec_res.valid;
      q_ctrl.run_end          = src_take && src_final;
      push_word.code_point    = dec_res.code_point;
      push_word.encoding_now  = dec_res.enc;
      push_word.mark_found    = mark_ff;
      push_word.last_of_run   = 1'b0;
   end

   ubd_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .push_word (push_word),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         init_enc_ff    <= 3'd0;
         head_cnt_ff    <= 2'd0;
         decided_ff     <= 1'b0;
         mark_ff        <= 1'b0;
         dec_ff         <= '0;
         replay_ff      <= 1'b0;
         replay_idx_ff  <= 2'd0;
         replay_last_ff <= 2'd0;
         replay_eos_ff  <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         init_enc_ff    <= init_enc_in;
         head_cnt_ff    <= head_cnt_in;
         decided_ff     <= decided_in;
         mark_ff        <= mark_in;
         dec_ff         <= dec_in;
         replay_ff      <= replay_in;
         replay_idx_ff  <= replay_idx_in;
         replay_last_ff <= replay_last_in;
         replay_eos_ff  <= replay_eos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      head_ff <= head_in;
   end

   a_replay_after_decision: assert property (@(posedge clock) disable iff (reset)
      replay_ff |-> decided_ff)
      else $error("held bytes replayed before the mark decision");

   a_head_only_undecided: assert property (@(posedge clock) disable iff (reset)
      head_cnt_ff != 2'd0 |-> !decided_ff)
      else $error("bytes held after the mark decision");

   a_stream_end_clears: assert property (@(posedge clock) disable iff (reset)
      src_take && src_final && src_eos |=> !decided_ff && !replay_ff && !mark_ff)
      else $error("stream state not cleared after end of stream");

endmodule

`default_nettype wire

@@ tb/unicode_stream_decoder_bom_test.sv @@
// self-checking testbench for the unicode stream decoder: directed byte table, then random streams
`timescale 1ns / 100ps

module unicode_stream_decoder_bom_test;
   import ubd_pkg::*;

   localparam int MAX_RUN     = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 12;
   localparam int PHASES      = 7;
   localparam int PHASE_BYTES = 33;
   localparam int LONG_HOLD   = 300;

   typedef struct packed {
      logic [7:0]  data;
      logic        eos;
      logic        typed;
      logic [31:0] cp;
      enc_type     enc;
   } byte_row_type;

   typedef struct packed {
      logic         typed;
      rsp_word_type word;
   } row_tag_type;

   logic         clock;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_stall;
   req_word_type req_word         = '0;
   logic         rsp_valid;
   logic         rsp_stall        = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [2:0]   csr_write_data   = '0;

   // decoder state kept alongside the block
   logic [2:0]   dec_cfg;
   logic [7:0]   dec_head [4];
   int           dec_head_n;
   logic         dec_decided;
   enc_type      dec_enc;
   logic         dec_mark;
   logic [31:0]  dec_acc;
   int           dec_acc_n;
   logic [15:0]  dec_pend;
   int           dec_u8_left;

   rsp_word_type step_words [$];
   rsp_word_type decoded_words_due [$];
   row_tag_type  offered_rows [$];
   byte_row_type byte_rows [$];
   logic [7:0]   stream_q [$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int send_calm      = 0;
   int recv_calm      = 0;
   int long_hold      = 0;

   unicode_stream_decoder_bom DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic enc_type fresh_encoding(input logic [2:0] value);
      enc_type enc;
      if (value > 3'(ENC_ASCII)) begin
         enc = ENC_UTF8;
      end else begin
         enc = enc_type'(value);
      end
      return enc;
   endfunction

   function automatic void clear_decoder();
      for (int i = 0; i < 4; i++) begin
         dec_head[i] = 8'h00;
      end
      dec_head_n  = 0;
      dec_decided = 1'b0;
      dec_enc     = fresh_encoding(dec_cfg);
      dec_mark    = 1'b0;
      dec_acc     = '0;
      dec_acc_n   = 0;
      dec_pend    = '0;
      dec_u8_left = 0;
   endfunction

   function automatic void emit_code(input logic [31:0] cp);
      rsp_word_type w;
      if (step_words.size() < MAX_RUN) begin
         w.code_point   = cp;
         w.encoding_now = dec_enc;
         w.mark_found   = dec_mark;
         w.last_of_run  = 1'b0;
         step_words.push_back(w);
      end
   endfunction

   function automatic void ascii_byte(input logic [7:0] b);
      if (b != 8'h00 && b < UTF8_CONT) begin
         emit_code({24'h0, b});
      end
   endfunction

   function automatic void fall_to_ascii();
      dec_enc     = ENC_ASCII;
      dec_acc     = '0;
      dec_acc_n   = 0;
      dec_u8_left = 0;
   endfunction

   function automatic void utf16_unit(input logic [15:0] u);
      logic surr;
      surr = (u & 16'hF800) == SURR_LOW[15:0];
      if (dec_pend != 16'h0) begin
         // a surrogate after any surrogate pairs up, anything else drops both
         if (surr) begin
            emit_code(SUPP_BASE + {12'h0, dec_pend[9:0], u[9:0]});
         end
         dec_pend = 16'h0;
      end else if (surr) begin
         dec_pend = u;
      end else begin
         emit_code({16'h0, u});
      end
   endfunction

   function automatic void utf8_byte(input logic [7:0] b);
      logic [31:0] v;
      logic [31:0] minv;
      if (dec_u8_left == 0) begin
         if (b == 8'h00) begin
            fall_to_ascii();
         end else if (b < UTF8_CONT) begin
            emit_code({24'h0, b});
         end else if (b < UTF8_LEAD2) begin
            fall_to_ascii();
         end else if (b < UTF8_LEAD3) begin
            dec_acc = {27'h0, b[4:0]};
            dec_u8_left = 1;
            dec_acc_n = 1;
         end else if (b < UTF8_LEAD4) begin
            dec_acc = {28'h0, b[3:0]};
            dec_u8_left = 2;
            dec_acc_n = 2;
         end else if (b < UTF8_BAD) begin
            dec_acc = {29'h0, b[2:0]};
            dec_u8_left = 3;
            dec_acc_n = 3;
         end else begin
            fall_to_ascii();
         end
      end else if (b[7:6] != 2'b10) begin
         // missing continuation: the byte itself is taken as ascii
         fall_to_ascii();
         ascii_byte(b);
      end else begin
         dec_acc = ((dec_acc << 6) | {26'h0, b[5:0]}) & 32'h001F_FFFF;
         dec_u8_left--;
         if (dec_u8_left == 0) begin
            v = dec_acc;
            minv = (dec_acc_n == 1) ? 32'h80 : (dec_acc_n == 2) ? 32'h800 : SUPP_BASE;
            dec_acc = '0;
            dec_acc_n = 0;
            if (v < minv || (v >= SURR_LOW && v <= SURR_HIGH) || v > CP_MAX) begin
               fall_to_ascii();
            end else begin
               emit_code(v);
            end
         end
      end
   endfunction

   function automatic void decode_unit_byte(input logic [7:0] b);
      logic [15:0] u;
      case (dec_enc)
         ENC_U32BE, ENC_U32LE: begin
            if (dec_enc == ENC_U32BE) begin
               dec_acc = {dec_acc[23:0], b};
            end else begin
               dec_acc = {b, dec_acc[31:8]};
            end
            if (dec_acc_n == 3) begin
               emit_code(dec_acc);
               dec_acc = '0;
               dec_acc_n = 0;
            end else begin
               dec_acc_n++;
            end
         end
         ENC_U16BE, ENC_U16LE: begin
            if (dec_acc_n == 0) begin
               dec_acc = {24'h0, b};
               dec_acc_n = 1;
            end else begin
               u = (dec_enc == ENC_U16BE) ? {dec_acc[7:0], b} : {b, dec_acc[7:0]};
               dec_acc = '0;
               dec_acc_n = 0;
               utf16_unit(u);
            end
         end
         ENC_ASCII: begin
            ascii_byte(b);
         end
         default: begin
            utf8_byte(b);
         end
      endcase
   endfunction

   function automatic void settle_mark();
      int held;
      int skip;
      held = dec_head_n;
      skip = 0;
      if (held >= 4 && dec_head[0] == BYTE_00 && dec_head[1] == BYTE_00 &&
          dec_head[2] == BYTE_FE && dec_head[3] == BYTE_FF) begin
         dec_enc = ENC_U32BE;
         skip = 4;
      end else if (held >= 4 && dec_head[0] == BYTE_FF && dec_head[1] == BYTE_FE &&
                   dec_head[2] == BYTE_00 && dec_head[3] == BYTE_00) begin
         dec_enc = ENC_U32LE;
         skip = 4;
      end else if (held >= 3 && dec_head[0] == BYTE_EF && dec_head[1] == BYTE_BB &&
                   dec_head[2] == BYTE_BF) begin
         dec_enc = ENC_UTF8;
         skip = 3;
      end else if (held >= 2 && dec_head[0] == BYTE_FE && dec_head[1] == BYTE_FF) begin
         dec_enc = ENC_U16BE;
         skip = 2;
      end else if (held >= 2 && dec_head[0] == BYTE_FF && dec_head[1] == BYTE_FE) begin
         dec_enc = ENC_U16LE;
         skip = 2;
      end
      if (skip != 0) begin
         dec_mark = 1'b1;
      end
      dec_decided = 1'b1;
      dec_head_n = 0;
      // bytes held past the mark go through the decoder in order
      for (int i = skip; i < held; i++) begin
         decode_unit_byte(dec_head[i]);
      end
   endfunction

   function automatic void decode_stream_byte(input req_word_type w);
      rsp_word_type tail;
      step_words.delete();
      if (!dec_decided) begin
         dec_head[dec_head_n % 4] = w.data_byte;
         dec_head_n++;
         if (dec_head_n >= 4 || w.end_of_stream) begin
            settle_mark();
         end
      end else begin
         decode_unit_byte(w.data_byte);
      end
      if (w.end_of_stream) begin
         clear_decoder();
      end
      if (step_words.size() != 0) begin
         tail = step_words.pop_back();
         tail.last_of_run = 1'b1;
         step_words.push_back(tail);
      end
   endfunction

   function automatic void note_mismatch(input string what, input rsp_word_type due,
                                         input rsp_word_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: due cp=%h enc=%0d mark=%b last=%b, got cp=%h enc=%0d mark=%b last=%b",
                  $time, what, due.code_point, due.encoding_now, due.mark_found, due.last_of_run,
                  got.code_point, got.encoding_now, got.mark_found, got.last_of_run);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type due;
      row_tag_type  tag;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else if (reset) begin
         dec_cfg = 3'(ENC_UTF8);
         clear_decoder();
      end else begin
         if (csr_write_enable) begin
            dec_cfg = csr_write_data;
            if (!dec_decided) begin
               dec_enc = fresh_encoding(csr_write_data);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_words_due.size() == 0) begin
               note_mismatch("word with none due", '0, rsp_word);
            end else begin
               due = decoded_words_due.pop_front();
               if (due.code_point != rsp_word.code_point ||
                   due.encoding_now != rsp_word.encoding_now ||
                   due.mark_found != rsp_word.mark_found ||
                   due.last_of_run != rsp_word.last_of_run) begin
                  note_mismatch("word mismatch", due, rsp_word);
               end
            end
         end
         if (req_valid && !req_stall) begin
            tag = offered_rows.pop_front();
            decode_stream_byte(req_word);
            if (tag.typed) begin
               decoded_words_due.push_back(tag.word);
            end else begin
               foreach (step_words[i]) begin
                  decoded_words_due.push_back(step_words[i]);
               end
            end
         end
      end
   end

   task automatic draw_wait(inout int calm_left, output int cycles);
      if (calm_left > 0) begin
         calm_left--;
         cycles = 0;
      end else begin
         if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(10, 40);
         end
         cycles = $urandom_range(0, 17);
      end
   endtask

   // result side: random stall per word, plus one long hold-off on request
   initial begin : sink
      int stall_len;
      @(negedge clock);
      forever begin
         draw_wait(recv_calm, stall_len);
         if (long_hold != 0) begin
            stall_len = long_hold;
            long_hold = 0;
         end
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || reset);
         @(negedge clock);
      end
   end

   task automatic send_word(input logic [7:0] data, input logic eos, input row_tag_type tag);
      int gap;
      draw_wait(send_calm, gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      offered_rows.push_back(tag);
      req_valid <= 1'b1;
      req_word.data_byte <= data;
      req_word.end_of_stream <= eos;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (decoded_words_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_encoding(input logic [2:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic put_unit(input enc_type enc, input logic [15:0] u);
      if (enc == ENC_U16BE) begin
         stream_q.push_back(u[15:8]);
         stream_q.push_back(u[7:0]);
      end else begin
         stream_q.push_back(u[7:0]);
         stream_q.push_back(u[15:8]);
      end
   endtask

   task automatic put_cp(input enc_type enc, input logic [31:0] cp);
      logic [31:0] c;
      case (enc)
         ENC_U32BE: begin
            stream_q.push_back(cp[31:24]);
            stream_q.push_back(cp[23:16]);
            stream_q.push_back(cp[15:8]);
            stream_q.push_back(cp[7:0]);
         end
         ENC_U32LE: begin
            stream_q.push_back(cp[7:0]);
            stream_q.push_back(cp[15:8]);
            stream_q.push_back(cp[23:16]);
            stream_q.push_back(cp[31:24]);
         end
         ENC_U16BE, ENC_U16LE: begin
            if (cp >= SUPP_BASE) begin
               c = cp - SUPP_BASE;
               put_unit(enc, {6'b110110, c[19:10]});
               put_unit(enc, {6'b110111, c[9:0]});
            end else begin
               put_unit(enc, cp[15:0]);
            end
         end
         default: begin
            if (cp < 32'h80) begin
               stream_q.push_back(cp[7:0]);
            end else if (cp < 32'h800) begin
               stream_q.push_back({3'b110, cp[10:6]});
               stream_q.push_back({2'b10, cp[5:0]});
            end else if (cp < SUPP_BASE) begin
               stream_q.push_back({4'b1110, cp[15:12]});
               stream_q.push_back({2'b10, cp[11:6]});
               stream_q.push_back({2'b10, cp[5:0]});
            end else begin
               stream_q.push_back({5'b11110, cp[20:18]});
               stream_q.push_back({2'b10, cp[17:12]});
               stream_q.push_back({2'b10, cp[11:6]});
               stream_q.push_back({2'b10, cp[5:0]});
            end
         end
      endcase
   endtask

   // one stream: mostly a mark and well-formed text, some noise and damage
   task automatic make_stream(input logic [2:0] cfg);
      int          pick;
      int          n_chars;
      enc_type     enc;
      logic [31:0] cp;
      stream_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         n_chars = $urandom_range(1, 8);
         repeat (n_chars) stream_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         enc = fresh_encoding(cfg);
         pick = $urandom_range(0, ENC_ASCII);
         if (pick != ENC_ASCII) begin
            enc = enc_type'(pick);
            case (enc)
               ENC_U32BE: begin
                  stream_q.push_back(BYTE_00);
                  stream_q.push_back(BYTE_00);
                  stream_q.push_back(BYTE_FE);
                  stream_q.push_back(BYTE_FF);
               end
               ENC_U32LE: begin
                  stream_q.push_back(BYTE_FF);
                  stream_q.push_back(BYTE_FE);
                  stream_q.push_back(BYTE_00);
                  stream_q.push_back(BYTE_00);
               end
               ENC_UTF8: begin
                  stream_q.push_back(BYTE_EF);
                  stream_q.push_back(BYTE_BB);
                  stream_q.push_back(BYTE_BF);
               end
               ENC_U16BE: begin
                  stream_q.push_back(BYTE_FE);
                  stream_q.push_back(BYTE_FF);
               end
               default: begin
                  stream_q.push_back(BYTE_FF);
                  stream_q.push_back(BYTE_FE);
               end
            endcase
         end
         n_chars = $urandom_range(0, 5);
         repeat (n_chars) begin
            case ($urandom_range(0, 4))
               0: cp = $urandom_range(0, 127);
               1: cp = $urandom_range(128, 2047);
               2: begin
                  cp = $urandom_range(2048, 65535);
                  if (cp >= SURR_LOW && cp <= SURR_HIGH) begin
                     cp = cp ^ 32'h2000;
                  end
               end
               3: cp = $urandom_range(65536, 1114111);
               default: begin
                  // raw surrogates, or any 32-bit value where the word is wide enough
                  if (enc == ENC_U32BE || enc == ENC_U32LE) begin
                     cp = $urandom;
                  end else begin
                     cp = $urandom_range(55296, 57343);
                  end
               end
            endcase
            put_cp(enc, cp);
         end
         if ($urandom_range(0, 7) == 0 && stream_q.size() > 0) begin
            stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 7) == 0 && stream_q.size() > 1) begin
            void'(stream_q.pop_back());
         end
      end
      if (stream_q.size() == 0) begin
         stream_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   function automatic byte_row_type plain_row(input logic [7:0] data, input logic eos);
      byte_row_type r;
      r = '0;
      r.data = data;
      r.eos = eos;
      return r;
   endfunction

   function automatic byte_row_type known_row(input logic [7:0] data, input logic eos,
                                              input logic [31:0] cp, input enc_type enc);
      byte_row_type r;
      r = plain_row(data, eos);
      r.typed = 1'b1;
      r.cp = cp;
      r.enc = enc;
      return r;
   endfunction

   initial begin : stimulus
      row_tag_type tag;
      logic [2:0]  cfg;
      int          sent;

      // utf-8 mark, then a lead byte with a missing continuation
      byte_rows.push_back(plain_row(8'hEF, 1'b0));
      byte_rows.push_back(plain_row(8'hBB, 1'b0));
      byte_rows.push_back(plain_row(8'hBF, 1'b0));
      byte_rows.push_back(known_row(8'h41, 1'b0, 32'h41, ENC_UTF8));
      byte_rows.push_back(plain_row(8'hC0, 1'b0));
      byte_rows.push_back(known_row(8'h41, 1'b0, 32'h41, ENC_ASCII));
      byte_rows.push_back(plain_row(8'h00, 1'b1));
      // utf-32 little endian mark and the widest word
      byte_rows.push_back(plain_row(8'hFF, 1'b0));
      byte_rows.push_back(plain_row(8'hFE, 1'b0));
      byte_rows.push_back(plain_row(8'h00, 1'b0));
      byte_rows.push_back(plain_row(8'h00, 1'b0));
      byte_rows.push_back(plain_row(8'hFF, 1'b0));
      byte_rows.push_back(plain_row(8'hFF, 1'b0));
      byte_rows.push_back(plain_row(8'hFF, 1'b0));
      byte_rows.push_back(known_row(8'hFF, 1'b1, 32'hFFFF_FFFF, ENC_U32LE));
      // utf-16 big endian: surrogate pair, then a surrogate before a plain unit
      byte_rows.push_back(plain_row(8'hFE, 1'b0));
      byte_rows.push_back(plain_row(8'hFF, 1'b0));
      byte_rows.push_back(plain_row(8'hD8, 1'b0));
      byte_rows.push_back(plain_row(8'h00, 1'b0));
      byte_rows.push_back(plain_row(8'hDC, 1'b0));
      byte_rows.push_back(known_row(8'h00, 1'b0, 32'h0001_0000, ENC_U16BE));
      byte_rows.push_back(plain_row(8'hDB, 1'b0));
      byte_rows.push_back(plain_row(8'hFF, 1'b0));
      byte_rows.push_back(plain_row(8'h00, 1'b0));
      byte_rows.push_back(plain_row(8'h41, 1'b1));

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (byte_rows[i]) begin
         tag.typed = byte_rows[i].typed;
         tag.word.code_point = byte_rows[i].cp;
         tag.word.encoding_now = byte_rows[i].enc;
         tag.word.mark_found = 1'b1;
         tag.word.last_of_run = 1'b1;
         send_word(byte_rows[i].data, byte_rows[i].eos, tag);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         cfg = (p < 5) ? 3'(4 - p) : 3'($urandom_range(0, 4));
         write_encoding(cfg);
         if (p == 2) begin
            // receiver holds off while the sender keeps offering back to back
            long_hold = LONG_HOLD;
            send_calm = 60;
         end
         sent = 0;
         while (sent < PHASE_BYTES) begin
            make_stream(cfg);
            foreach (stream_q[i]) begin
               tag = '0;
               send_word(stream_q[i], i == stream_q.size() - 1, tag);
               sent++;
            end
         end
         req_valid <= 1'b0;
      end

      wait_idle();
      if (mismatch_count == 0 && decoded_words_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
